/* hdl/matrix3x3_inverse_top_assert.svh */
// Assertion macros for the 3x3 matrix inverse block.
`ifndef MATRIX3X3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3X3_INVERSE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define M3INV_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define M3INV_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define M3INV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define M3INV_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define M3INV_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define M3INV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/m3inv_pkg.sv */
// Widths, types and operand tables of the 3x3 matrix inverse block.
package m3inv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int LANES     = 9;
   localparam int EW        = 32;
   localparam int PW        = 2 * EW;
   localparam int CW        = PW + 1;
   localparam int DW        = CW + EW + 1;
   localparam int MW        = DW - 1;
   localparam int QW        = EW;
   localparam int NW        = MW + 1 + QW;
   localparam int RMW       = MW - FRAC_BITS;
   localparam int DSTAGES   = QW + 2;

   localparam logic [MW-1:0] HALF_LSB = MW'(1) << (FRAC_BITS - 1);

   // product operands, two per cofactor: cof = first - second
   localparam int unsigned OPA [2*LANES] = '{4, 5, 2, 1, 1, 2, 5, 3, 0,
                                             2, 2, 0, 3, 4, 1, 0, 0, 1};
   localparam int unsigned OPB [2*LANES] = '{8, 7, 7, 8, 5, 4, 6, 8, 8,
                                             6, 3, 5, 7, 6, 6, 7, 4, 3};

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [CW-1:0] cof_type;
   typedef logic signed [DW-1:0] det_type;

   typedef struct packed {
      logic [LANES-1:0]          negq;
      logic                      singular;
      logic [PW-1:0]             det_out;
      logic [MW:0]               dvs;
      logic [LANES-1:0][QW:0]    quo;
      logic [LANES-1:0][NW-1:0]  rem;
   } div_type;

endpackage

/* hdl/m3inv_req_if.sv */
// Request channel carrying one 3x3 matrix.
interface m3inv_req_if import m3inv_pkg::*; ();
   logic     valid;
   logic     ready;
   elem_type m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 output ready);
endinterface

/* hdl/m3inv_rsp_if.sv */
// Response channel carrying the inverse, determinant and flags.
interface m3inv_rsp_if import m3inv_pkg::*; ();
   logic          valid;
   logic          ready;
   elem_type      r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic [PW-1:0] determinant;
   logic          singular;
   logic          overflow;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   determinant, singular, overflow, input ready);
   modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                 determinant, singular, overflow, output ready);
endinterface

/* hdl/matrix3x3_inverse_top.sv */
// Pipelined 3x3 fixed-point matrix inverse by adjugate and determinant.
//
//   channel   direction  handshake          payload
//   req_ch    in         valid/ready        m00..m22, Q16.16
//   rsp_ch    out        valid/ready        r00..r22, determinant, singular, overflow
//
// One matrix enters per cycle unless the response stalls; the pipeline has
// six arithmetic stages, an operand set-up stage, 33 restoring divide
// stages (one quotient bit each, nine lanes) and the response register.
// Reset clears the valid bits only.
// A stalled response freezes the whole pipeline; no request is dropped.
module matrix3x3_inverse_top import m3inv_pkg::*; (
   input logic         clock,
   input logic         reset,
   m3inv_req_if.sink   req_ch,
   m3inv_rsp_if.source rsp_ch
);

   logic adv;

   elem_type req_m [LANES];

   logic     s1_v_ff;
   prod_type s1_p_in  [2*LANES];
   prod_type s1_p_ff  [2*LANES];
   elem_type s1_m0_ff [3];

   logic     s2_v_ff;
   cof_type  s2_cof_in [LANES];
   cof_type  s2_cof_ff [LANES];
   elem_type s2_m0_ff  [3];

   logic             s3_v_ff;
   cof_type          s3_lo_in [3];
   cof_type          s3_lo_ff [3];
   cof_type          s3_hi_in [3];
   cof_type          s3_hi_ff [3];
   logic [CW-1:0]    s3_cmag_in [LANES];
   logic [CW-1:0]    s3_cmag_ff [LANES];
   logic [LANES-1:0] s3_cneg_ff;

   logic             s4_v_ff;
   det_type          s4_t_in [3];
   det_type          s4_t_ff [3];
   logic [CW-1:0]    s4_cmag_ff [LANES];
   logic [LANES-1:0] s4_cneg_ff;

   logic             s5_v_ff;
   det_type          s5_det_ff;
   logic [CW-1:0]    s5_cmag_ff [LANES];
   logic [LANES-1:0] s5_cneg_ff;

   logic             s6_v_ff;
   logic [MW-1:0]    s6_dmag_in;
   logic [MW-1:0]    s6_dmag_ff;
   logic [CW-1:0]    s6_cmag_ff [LANES];
   logic [LANES-1:0] s6_negq_ff;
   logic             s6_dneg_ff;
   logic             s6_sing_ff;

   div_type            div_in [DSTAGES];
   div_type            div_ff [DSTAGES];
   logic [DSTAGES-1:0] dv_ff;

   logic          rsp_valid_ff;
   elem_type      rsp_r_in [LANES];
   elem_type      rsp_r_ff [LANES];
   logic [PW-1:0] rsp_det_in;
   logic [PW-1:0] rsp_det_ff;
   logic          rsp_sing_in;
   logic          rsp_sing_ff;
   logic          rsp_ovf_in;
   logic          rsp_ovf_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_comb begin
      req_m[0] = req_ch.m00;
      req_m[1] = req_ch.m01;
      req_m[2] = req_ch.m02;
      req_m[3] = req_ch.m10;
      req_m[4] = req_ch.m11;
      req_m[5] = req_ch.m12;
      req_m[6] = req_ch.m20;
      req_m[7] = req_ch.m21;
      req_m[8] = req_ch.m22;
   end

   always_comb begin
      for (int i = 0; i < 2*LANES; i++) begin
         s1_p_in[i] = PW'(req_m[OPA[i]]) * PW'(req_m[OPB[i]]);
      end
      for (int i = 0; i < LANES; i++) begin
         s2_cof_in[i] = CW'(s1_p_ff[2*i]) - CW'(s1_p_ff[2*i+1]);
         s3_cmag_in[i] = s2_cof_ff[i][CW-1] ? $unsigned(-s2_cof_ff[i])
                                            : $unsigned(s2_cof_ff[i]);
      end
      // expand along row 0 in two halves of each cofactor
      for (int j = 0; j < 3; j++) begin
         s3_lo_in[j] = CW'(s2_m0_ff[j]) * CW'($signed({1'b0, s2_cof_ff[3*j][EW-1:0]}));
         s3_hi_in[j] = CW'(s2_m0_ff[j]) * CW'($signed(s2_cof_ff[3*j][CW-1:EW]));
         s4_t_in[j]  = (DW'(s3_hi_ff[j]) <<< EW) + DW'(s3_lo_ff[j]);
      end
      s6_dmag_in = s5_det_ff[DW-1] ? MW'($unsigned(-s5_det_ff))
                                   : MW'($unsigned(s5_det_ff));
   end

   always_comb begin
      logic [MW-1:0]  rnd;
      logic [RMW-1:0] rmag;
      logic [NW-1:0]  shd;
      rnd  = s6_dmag_ff + HALF_LSB;
      rmag = rnd[MW-1:FRAC_BITS];
      div_in[0].negq     = s6_negq_ff;
      div_in[0].singular = s6_sing_ff;
      div_in[0].dvs      = {s6_dmag_ff, 1'b0};
      div_in[0].quo      = '0;
      for (int l = 0; l < LANES; l++) begin
         div_in[0].rem[l] = (NW'(s6_cmag_ff[l]) << (2*FRAC_BITS + 1)) + NW'(s6_dmag_ff);
      end
      if (s6_dneg_ff) begin
         if ((|rmag[RMW-1:PW]) || (rmag[PW-1] && (|rmag[PW-2:0]))) begin
            div_in[0].det_out = {1'b1, {(PW-1){1'b0}}};
         end else begin
            div_in[0].det_out = -rmag[PW-1:0];
         end
      end else begin
         if (|rmag[RMW-1:PW-1]) begin
            div_in[0].det_out = {1'b0, {(PW-1){1'b1}}};
         end else begin
            div_in[0].det_out = rmag[PW-1:0];
         end
      end
      // one restoring quotient bit per stage, top bit flags overflow
      for (int i = 1; i < DSTAGES; i++) begin
         div_in[i] = div_ff[i-1];
         shd = NW'(div_ff[i-1].dvs) << (QW + 1 - i);
         for (int l = 0; l < LANES; l++) begin
            if (div_ff[i-1].rem[l] >= shd) begin
               div_in[i].rem[l]          = div_ff[i-1].rem[l] - shd;
               div_in[i].quo[l][QW+1-i]  = 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic [QW-1:0] maxpos;
      logic [QW-1:0] lim;
      logic          sat;
      rsp_ovf_in  = 1'b0;
      rsp_sing_in = div_ff[DSTAGES-1].singular;
      rsp_det_in  = rsp_sing_in ? '0 : div_ff[DSTAGES-1].det_out;
      for (int l = 0; l < LANES; l++) begin
         maxpos = div_ff[DSTAGES-1].negq[l] ? {1'b1, {(QW-1){1'b0}}}
                                            : {1'b0, {(QW-1){1'b1}}};
         sat    = div_ff[DSTAGES-1].quo[l][QW] || (div_ff[DSTAGES-1].quo[l][QW-1:0] > maxpos);
         lim    = sat ? maxpos : div_ff[DSTAGES-1].quo[l][QW-1:0];
         if (rsp_sing_in) begin
            rsp_r_in[l] = '0;
         end else begin
            rsp_r_in[l] = div_ff[DSTAGES-1].negq[l] ? $signed(-lim) : $signed(lim);
            rsp_ovf_in  = rsp_ovf_in | sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         s6_v_ff      <= 1'b0;
         dv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= req_ch.valid;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         s4_v_ff      <= s3_v_ff;
         s5_v_ff      <= s4_v_ff;
         s6_v_ff      <= s5_v_ff;
         dv_ff        <= {dv_ff[DSTAGES-2:0], s6_v_ff};
         rsp_valid_ff <= dv_ff[DSTAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p_ff     <= s1_p_in;
         s1_m0_ff[0] <= req_m[0];
         s1_m0_ff[1] <= req_m[1];
         s1_m0_ff[2] <= req_m[2];
         s2_cof_ff   <= s2_cof_in;
         s2_m0_ff    <= s1_m0_ff;
         s3_lo_ff    <= s3_lo_in;
         s3_hi_ff    <= s3_hi_in;
         s3_cmag_ff  <= s3_cmag_in;
         for (int i = 0; i < LANES; i++) begin
            s3_cneg_ff[i] <= s2_cof_ff[i][CW-1];
         end
         s4_t_ff     <= s4_t_in;
         s4_cmag_ff  <= s3_cmag_ff;
         s4_cneg_ff  <= s3_cneg_ff;
         s5_det_ff   <= s4_t_ff[0] + s4_t_ff[1] + s4_t_ff[2];
         s5_cmag_ff  <= s4_cmag_ff;
         s5_cneg_ff  <= s4_cneg_ff;
         s6_dmag_ff  <= s6_dmag_in;
         s6_cmag_ff  <= s5_cmag_ff;
         s6_negq_ff  <= s5_cneg_ff ^ {LANES{s5_det_ff[DW-1]}};
         s6_dneg_ff  <= s5_det_ff[DW-1];
         s6_sing_ff  <= (s5_det_ff == '0);
         div_ff      <= div_in;
         rsp_r_ff    <= rsp_r_in;
         rsp_det_ff  <= rsp_det_in;
         rsp_sing_ff <= rsp_sing_in;
         rsp_ovf_ff  <= rsp_ovf_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.r00         = rsp_r_ff[0];
   assign rsp_ch.r01         = rsp_r_ff[1];
   assign rsp_ch.r02         = rsp_r_ff[2];
   assign rsp_ch.r10         = rsp_r_ff[3];
   assign rsp_ch.r11         = rsp_r_ff[4];
   assign rsp_ch.r12         = rsp_r_ff[5];
   assign rsp_ch.r20         = rsp_r_ff[6];
   assign rsp_ch.r21         = rsp_r_ff[7];
   assign rsp_ch.r22         = rsp_r_ff[8];
   assign rsp_ch.determinant = rsp_det_ff;
   assign rsp_ch.singular    = rsp_sing_ff;
   assign rsp_ch.overflow    = rsp_ovf_ff;

`include "matrix3x3_inverse_top_assert.svh"

   `M3INV_ASSERT_ALWAYS(a_ready_follows_rsp, clock, reset, req_ch.ready == (!rsp_ch.valid || rsp_ch.ready), "request ready does not follow response slot")
   `M3INV_ASSERT_IMPLIES(a_singular_clean, clock, reset, rsp_ch.valid && rsp_ch.singular, !rsp_ch.overflow && rsp_ch.determinant == '0, "singular response carries data")
   `M3INV_ASSERT_NEXT(a_stall_freezes, clock, reset, !adv, $stable(dv_ff) && $stable(s6_v_ff), "pipeline moved during stall")

endmodule

/* sim/tb_matrix3x3_inverse_top.sv */
// Testbench for the 3x3 matrix inverse block: directed and random matrices against a predictor.
`timescale 1ns / 100ps

module tb_matrix3x3_inverse_top import m3inv_pkg::*; ();

   localparam int  CYCLE_LIMIT = 400000;
   localparam int  DRAIN_CYCLES = 60;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   typedef logic signed [127:0] wide_type;
   typedef elem_type matrix_type [9];

   typedef struct {
      elem_type    r [9];
      logic [63:0] det;
      logic        singular;
      logic        overflow;
   } inverse_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          cycles = 0;
   int          errors = 0;
   inverse_type expected_inverses [$];

   m3inv_req_if req_ch ();
   m3inv_rsp_if rsp_ch ();

   matrix3x3_inverse_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic wide_type wabs(input wide_type x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic inverse_type invert(input matrix_type m);
      inverse_type res;
      wide_type    w [9];
      wide_type    cof [9];
      wide_type    det, dmag, mag, num, den;
      logic [31:0] maxpos;
      logic [31:0] lim;
      logic        negq;
      for (int i = 0; i < 9; i++) w[i] = m[i];
      cof[0] = w[4]*w[8] - w[5]*w[7];
      cof[1] = w[2]*w[7] - w[1]*w[8];
      cof[2] = w[1]*w[5] - w[2]*w[4];
      cof[3] = w[5]*w[6] - w[3]*w[8];
      cof[4] = w[0]*w[8] - w[2]*w[6];
      cof[5] = w[2]*w[3] - w[0]*w[5];
      cof[6] = w[3]*w[7] - w[4]*w[6];
      cof[7] = w[1]*w[6] - w[0]*w[7];
      cof[8] = w[0]*w[4] - w[1]*w[3];
      det = w[0]*w[4]*w[8] + w[1]*w[5]*w[6] + w[2]*w[3]*w[7]
          - w[0]*w[5]*w[7] - w[1]*w[3]*w[8] - w[2]*w[4]*w[6];
      res.singular = 1'b0;
      res.overflow = 1'b0;
      if (det == 0) begin
         foreach (res.r[i]) res.r[i] = '0;
         res.det = '0;
         res.singular = 1'b1;
         return res;
      end
      dmag = wabs(det);
      mag = (dmag + (wide_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (det < 0)
         res.det = (mag > wide_type'(64'h8000000000000000)) ? 64'h8000000000000000
                                                            : 64'(-mag);
      else
         res.det = (mag > wide_type'(64'h7FFFFFFFFFFFFFFF)) ? 64'h7FFFFFFFFFFFFFFF
                                                            : 64'(mag);
      den = dmag <<< 1;
      for (int i = 0; i < 9; i++) begin
         negq = (cof[i] < 0) != (det < 0);
         num = ((wabs(cof[i]) <<< (2 * FRAC_BITS)) <<< 1) + dmag;
         mag = $unsigned(num) / $unsigned(den);
         maxpos = negq ? 32'h80000000 : 32'h7FFFFFFF;
         lim = mag[31:0];
         if (mag > wide_type'(maxpos)) begin
            lim = maxpos;
            res.overflow = 1'b1;
         end
         res.r[i] = negq ? -lim : lim;
      end
      return res;
   endfunction

   // call only just after a rising edge
   task automatic send_matrix(input matrix_type m);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.m00 <= m[0]; req_ch.m01 <= m[1]; req_ch.m02 <= m[2];
      req_ch.m10 <= m[3]; req_ch.m11 <= m[4]; req_ch.m12 <= m[5];
      req_ch.m20 <= m[6]; req_ch.m21 <= m[7]; req_ch.m22 <= m[8];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_inverses.push_back(invert(m));
   endtask

   task automatic wait_empty();
      req_ch.valid <= 1'b0;
      while (expected_inverses.size() != 0) @(posedge clock);
   endtask

   function automatic matrix_type diag(input elem_type a, b, c);
      matrix_type m;
      foreach (m[i]) m[i] = '0;
      m[0] = a; m[4] = b; m[8] = c;
      return m;
   endfunction

   function automatic matrix_type fill(input elem_type v);
      matrix_type m;
      foreach (m[i]) m[i] = v;
      return m;
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      int unsigned kind;
      int unsigned span;
      kind = $urandom_range(99);
      span = $urandom_range(4, 24);
      foreach (m[i]) begin
         if (kind < 25) m[i] = $urandom;
         else if (kind < 85) m[i] = $signed($urandom_range((1 << span) - 1)) - (1 << (span - 1));
         else m[i] = $signed($urandom_range(15)) - 8;
      end
      // duplicate a row for a singular matrix
      if (kind % 10 == 3) begin
         m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end
      return m;
   endfunction

   task automatic test_directed();
      matrix_type m;
      send_matrix(diag(ONE, ONE, ONE));
      send_matrix(diag(ONE * 2, -ONE, ONE / 4));
      send_matrix(fill(0));
      send_matrix(fill(32'sh80000000));
      send_matrix(fill(32'sh7FFFFFFF));
      send_matrix(diag(32'sh80000000, 32'sh80000000, 32'sh80000000));
      send_matrix(diag(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
      send_matrix(diag(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
      send_matrix(diag(1, 1, 1));
      send_matrix(diag(-1, 1, 1));
      send_matrix(diag(ONE, ONE, 1));
      send_matrix(diag(256, 256, 256));
      m = diag(ONE, ONE, ONE);
      m[1] = 32'shAAAAAAAA; m[5] = 32'sh55555555; m[6] = 32'sh55555555;
      send_matrix(m);
      m = fill(32'sh55555555);
      m[0] = 32'shAAAAAAAA; m[4] = 32'shAAAAAAAA; m[8] = 32'shAAAAAAAA;
      send_matrix(m);
      m = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE};
      send_matrix(m);
      m = '{2*ONE, -ONE, 0, -ONE, 2*ONE, -ONE, 0, -ONE, 2*ONE};
      send_matrix(m);
      m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};
      send_matrix(m);
      m = '{32'sh7FFFFFFF, 32'sh80000000, 1, -1, 32'sh7FFFFFFF, 0, 5, -7, 32'sh80000000};
      send_matrix(m);
      wait_empty();
   endtask

   task automatic test_random(input int idle, input int stall, input int count);
      idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_matrix(random_matrix());
   endtask

   task automatic test_pause_until_drained();
      repeat (40) send_matrix(random_matrix());
      wait_empty();
      repeat (40) send_matrix(random_matrix());
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      inverse_type exp_res;
      elem_type    got [9];
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.r00, rsp_ch.r01, rsp_ch.r02, rsp_ch.r10, rsp_ch.r11,
                 rsp_ch.r12, rsp_ch.r20, rsp_ch.r21, rsp_ch.r22};
         if (expected_inverses.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            exp_res = expected_inverses.pop_front();
            for (int i = 0; i < 9; i++)
               if (got[i] !== exp_res.r[i]) begin
                  $error("r%0d%0d: expected %0d, got %0d", i / 3, i % 3, exp_res.r[i], got[i]);
                  errors++;
               end
            if (rsp_ch.determinant !== exp_res.det) begin
               $error("determinant: expected %0d, got %0d",
                      $signed(exp_res.det), $signed(rsp_ch.determinant));
               errors++;
            end
            if (rsp_ch.singular !== exp_res.singular) begin
               $error("singular: expected %0b, got %0b", exp_res.singular, rsp_ch.singular);
               errors++;
            end
            if (rsp_ch.overflow !== exp_res.overflow) begin
               $error("overflow: expected %0b, got %0b", exp_res.overflow, rsp_ch.overflow);
               errors++;
            end
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.m00, req_ch.m01, req_ch.m02, req_ch.m10, req_ch.m11,
       req_ch.m12, req_ch.m20, req_ch.m21, req_ch.m22} = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(0, 0, 300);
      test_random(52, 0, 300);
      test_random(0, 52, 300);
      test_random(34, 34, 220);
      test_pause_until_drained();
      wait_empty();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
